FILE: src/sml_pkg.sv
// Shared constants, types and keyword tables for the slide markup lexer.
package sml_pkg;

    typedef logic [3:0] t_kind;
    typedef logic [1:0] t_mode;

    localparam t_kind K_SLIDE    = 4'd0;
    localparam t_kind K_TITLE    = 4'd1;
    localparam t_kind K_SUBTITLE = 4'd2;
    localparam t_kind K_STRING   = 4'd3;
    localparam t_kind K_NUMBER   = 4'd4;
    localparam t_kind K_IDENT    = 4'd5;
    localparam t_kind K_COLON    = 4'd6;
    localparam t_kind K_BULLET   = 4'd7;
    localparam t_kind K_END      = 4'd8;
    localparam t_kind K_UNKNOWN  = 4'd9;
    localparam t_kind K_NEWLINE  = 4'd10;

    localparam t_mode MODE_IDLE   = 2'd0;
    localparam t_mode MODE_STRING = 2'd1;
    localparam t_mode MODE_NUMBER = 2'd2;
    localparam t_mode MODE_WORD   = 2'd3;

    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_DASH  = 8'h2D;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;

    // result queue depth; one request may push two results
    localparam int FIFO_DEPTH = 4;

    // keyword spellings, bit k of the alive mask tracks row k
    localparam logic [7:0] KW_TEXT [3][8] = '{
        '{8'h73, 8'h6C, 8'h69, 8'h64, 8'h65, 8'h00, 8'h00, 8'h00},  // slide
        '{8'h74, 8'h69, 8'h74, 8'h6C, 8'h65, 8'h00, 8'h00, 8'h00},  // title
        '{8'h73, 8'h75, 8'h62, 8'h74, 8'h69, 8'h74, 8'h6C, 8'h65}   // subtitle
    };
    localparam logic [3:0] KW_LEN [3] = '{4'd5, 4'd5, 4'd8};

    function automatic logic is_digit(input logic [7:0] b);
        return (b >= 8'h30) && (b <= 8'h39);
    endfunction

    function automatic logic is_alpha(input logic [7:0] b);
        return ((b >= 8'h61) && (b <= 8'h7A)) || ((b >= 8'h41) && (b <= 8'h5A));
    endfunction

endpackage

FILE: src/slide_markup_lexer_top.sv
// Streaming lexer for slide markup: bytes in, tokens out through a small queue.
//
//  channel | valid   | ready   | payload
//  --------+---------+---------+---------------------------------------------
//  input   | i_valid | o_ready | i_text_byte, i_end_of_text
//  output  | o_valid | i_ready | o_token_kind, o_start_offset,
//          |         |         | o_token_length, o_unterminated, o_last_result
//
// One input request per cycle while o_ready is high. Each accepted byte is lexed
// in the cycle it is taken and its zero, one or two results land in a four-entry
// result queue, to be offered on the output after any results already waiting.
// o_ready stays high while the queue has room for two results, so the input
// rate is set by how fast results drain: one result per cycle on the output
// while i_ready is high. Reset (synchronous, active low) empties the queue and
// returns the lexer to idle at offset zero. An output stall fills the queue,
// and o_ready drops while three or more results wait.
module slide_markup_lexer_top #(
    parameter int OFFSET_BITS = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_ready,
    input  logic [7:0]             i_text_byte,
    input  logic                   i_end_of_text,
    output logic                   o_valid,
    input  logic                   i_ready,
    output sml_pkg::t_kind         o_token_kind,
    output logic [OFFSET_BITS-1:0] o_start_offset,
    output logic [OFFSET_BITS-1:0] o_token_length,
    output logic                   o_unterminated,
    output logic                   o_last_result
);
    import sml_pkg::*;

    localparam int PTR_BITS = $clog2(FIFO_DEPTH);
    localparam int CNT_BITS = $clog2(FIFO_DEPTH + 1);
    localparam logic [OFFSET_BITS-1:0] OFF_MAX = '1;

    typedef logic [OFFSET_BITS-1:0] t_off;

    typedef struct packed {
        t_kind kind;
        t_off  start;
        t_off  len;
        logic  unterm;
        logic  last;
    } t_result;

    function automatic t_off sat_inc(input t_off v);
        return (v == OFF_MAX) ? v : v + t_off'(1);
    endfunction

    // drop every keyword that no longer matches at this run position
    function automatic logic [2:0] kw_step(input logic [2:0] alive, input t_off pos,
                                           input logic [7:0] b);
        logic [2:0] a;
        a = alive;
        for (int k = 0; k < 3; k++) begin
            if ((pos >= t_off'(KW_LEN[k])) || (KW_TEXT[k][pos[2:0]] != b)) begin
                a[k] = 1'b0;
            end
        end
        return a;
    endfunction

    // lexer state
    t_mode      r_mode,      n_mode;
    t_off       r_tok_start, n_tok_start;
    t_off       r_run_len,   n_run_len;
    t_off       r_byte_pos,  n_byte_pos;
    logic [2:0] r_alive,     n_alive;

    // result queue
    t_result               r_fifo [FIFO_DEPTH];
    logic [PTR_BITS-1:0]   r_wr_ptr;
    logic [PTR_BITS-1:0]   r_rd_ptr;
    logic [CNT_BITS-1:0]   r_count;

    logic    in_fire;
    logic    out_fire;
    logic    a_v, b_v;
    t_result res_a, res_b;
    t_result flush_res;
    t_kind   word_kind;

    // what a byte does when no run is pending
    logic       ib_emit;
    t_kind      ib_kind;
    t_mode      ib_mode;
    t_off       ib_start;
    t_off       ib_len;
    logic [2:0] ib_alive;

    // results pushed this cycle
    logic [1:0] push_n;
    t_result    push0, push1;

    assign o_ready  = (r_count <= CNT_BITS'(FIFO_DEPTH - 2));
    assign in_fire  = i_valid && o_ready;
    assign o_valid  = (r_count != '0);
    assign out_fire = o_valid && i_ready;

    assign o_token_kind   = r_fifo[r_rd_ptr].kind;
    assign o_start_offset = r_fifo[r_rd_ptr].start;
    assign o_token_length = r_fifo[r_rd_ptr].len;
    assign o_unterminated = r_fifo[r_rd_ptr].unterm;
    assign o_last_result  = r_fifo[r_rd_ptr].last;

    // keyword decision for a finished letter run; slide wins over title
    always_comb begin
        priority if (r_alive[0] && (r_run_len == t_off'(KW_LEN[0]))) begin
            word_kind = K_SLIDE;
        end else if (r_alive[1] && (r_run_len == t_off'(KW_LEN[1]))) begin
            word_kind = K_TITLE;
        end else if (r_alive[2] && (r_run_len == t_off'(KW_LEN[2]))) begin
            word_kind = K_SUBTITLE;
        end else begin
            word_kind = K_IDENT;
        end
    end

    always_comb begin
        ib_emit  = 1'b0;
        ib_kind  = K_UNKNOWN;
        ib_mode  = MODE_IDLE;
        ib_start = r_tok_start;
        ib_len   = r_run_len;
        ib_alive = r_alive;
        priority if (i_text_byte == CH_COLON) begin
            ib_emit = 1'b1;
            ib_kind = K_COLON;
        end else if (i_text_byte == CH_DASH) begin
            ib_emit = 1'b1;
            ib_kind = K_BULLET;
        end else if (i_text_byte == CH_QUOTE) begin
            // string body starts after the quote
            ib_mode  = MODE_STRING;
            ib_start = sat_inc(r_byte_pos);
            ib_len   = '0;
        end else if ((i_text_byte == CH_SPACE) || (i_text_byte == CH_TAB) ||
                     (i_text_byte == CH_CR)) begin
            ib_emit = 1'b0;
        end else if (i_text_byte == CH_NL) begin
            ib_emit = 1'b1;
            ib_kind = K_NEWLINE;
        end else if (is_digit(i_text_byte)) begin
            ib_mode  = MODE_NUMBER;
            ib_start = r_byte_pos;
            ib_len   = t_off'(1);
        end else if (is_alpha(i_text_byte)) begin
            ib_mode  = MODE_WORD;
            ib_start = r_byte_pos;
            ib_len   = t_off'(1);
            ib_alive = kw_step(3'b111, '0, i_text_byte);
        end else begin
            ib_emit = 1'b1;
            ib_kind = K_UNKNOWN;
        end
    end

    always_comb begin
        flush_res.start  = r_tok_start;
        flush_res.len    = r_run_len;
        flush_res.unterm = 1'b0;
        flush_res.last   = 1'b0;
        unique case (r_mode)
            MODE_STRING: flush_res.kind = K_STRING;
            MODE_NUMBER: flush_res.kind = K_NUMBER;
            MODE_WORD:   flush_res.kind = word_kind;
            default:     flush_res.kind = K_IDENT;
        endcase

        n_mode      = r_mode;
        n_tok_start = r_tok_start;
        n_run_len   = r_run_len;
        n_byte_pos  = sat_inc(r_byte_pos);
        n_alive     = r_alive;
        a_v         = 1'b0;
        b_v         = 1'b0;
        res_a       = flush_res;
        res_b.kind   = ib_kind;
        res_b.start  = r_byte_pos;
        res_b.len    = '0;
        res_b.unterm = 1'b0;
        res_b.last   = 1'b1;

        if (i_end_of_text) begin
            // flush, end token, then back to reset state
            a_v          = (r_mode != MODE_IDLE);
            res_a.unterm = (r_mode == MODE_STRING);
            b_v          = 1'b1;
            res_b.kind   = K_END;
            n_mode      = MODE_IDLE;
            n_tok_start = '0;
            n_run_len   = '0;
            n_byte_pos  = '0;
            n_alive     = 3'b111;
        end else begin
            unique case (r_mode)
                MODE_STRING: begin
                    if (i_text_byte == CH_QUOTE) begin
                        a_v    = 1'b1;
                        n_mode = MODE_IDLE;
                    end else if (i_text_byte == CH_NL) begin
                        // unterminated; newline is lexed after the flush
                        a_v          = 1'b1;
                        res_a.unterm = 1'b1;
                        b_v          = ib_emit;
                        n_mode       = ib_mode;
                        n_tok_start  = ib_start;
                        n_run_len    = ib_len;
                        n_alive      = ib_alive;
                    end else begin
                        n_run_len = sat_inc(r_run_len);
                    end
                end
                MODE_NUMBER: begin
                    if (is_digit(i_text_byte)) begin
                        n_run_len = sat_inc(r_run_len);
                    end else begin
                        a_v         = 1'b1;
                        b_v         = ib_emit;
                        n_mode      = ib_mode;
                        n_tok_start = ib_start;
                        n_run_len   = ib_len;
                        n_alive     = ib_alive;
                    end
                end
                MODE_WORD: begin
                    if (is_alpha(i_text_byte)) begin
                        n_alive   = kw_step(r_alive, r_run_len, i_text_byte);
                        n_run_len = sat_inc(r_run_len);
                    end else begin
                        a_v         = 1'b1;
                        b_v         = ib_emit;
                        n_mode      = ib_mode;
                        n_tok_start = ib_start;
                        n_run_len   = ib_len;
                        n_alive     = ib_alive;
                    end
                end
                default: begin
                    b_v         = ib_emit;
                    n_mode      = ib_mode;
                    n_tok_start = ib_start;
                    n_run_len   = ib_len;
                    n_alive     = ib_alive;
                end
            endcase
        end

        // order results; the final one carries the last flag
        push0 = res_a;
        push1 = res_b;
        priority if (a_v && b_v) begin
            push_n = 2'd2;
        end else if (a_v) begin
            push_n     = 2'd1;
            push0.last = 1'b1;
        end else if (b_v) begin
            push_n = 2'd1;
            push0  = res_b;
        end else begin
            push_n = 2'd0;
        end
        if (!in_fire) begin
            push_n = 2'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= MODE_IDLE;
            r_tok_start <= '0;
            r_run_len   <= '0;
            r_byte_pos  <= '0;
            r_alive     <= 3'b111;
            r_wr_ptr    <= '0;
            r_rd_ptr    <= '0;
            r_count     <= '0;
        end else begin
            if (in_fire) begin
                r_mode      <= n_mode;
                r_tok_start <= n_tok_start;
                r_run_len   <= n_run_len;
                r_byte_pos  <= n_byte_pos;
                r_alive     <= n_alive;
            end
            r_wr_ptr <= r_wr_ptr + PTR_BITS'(push_n);
            if (out_fire) begin
                r_rd_ptr <= r_rd_ptr + PTR_BITS'(1);
            end
            r_count <= r_count + CNT_BITS'(push_n) - CNT_BITS'(out_fire);
        end
    end

    // queue payload, no reset
    always_ff @(posedge i_clk) begin
        if (push_n != 2'd0) begin
            r_fifo[r_wr_ptr] <= push0;
        end
        if (push_n == 2'd2) begin
            r_fifo[r_wr_ptr + PTR_BITS'(1)] <= push1;
        end
    end

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_BITS'(FIFO_DEPTH))
        else $error("result queue overfilled");

    a_eot_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && i_end_of_text) |=> (r_byte_pos == '0) && (r_mode == MODE_IDLE))
        else $error("lexer did not restart after end of text");

    a_end_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_token_kind == K_END)) |-> o_last_result)
        else $error("end token not flagged last");

    a_unterm_string: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_unterminated) |-> (o_token_kind == K_STRING))
        else $error("unterminated flag on a non-string token");
`endif

endmodule
